[hw/rtl/rtrd_pkg.sv]
// rtrd_pkg: shared types and constants for the text run-length decoder
// transaction structs for the request, the internal event queue and the response queue
// no dependencies
`default_nettype none

package rtrd_pkg;

   localparam logic [7:0]  CHAR_SPACE = 8'd32;
   localparam logic [7:0]  CHAR_ZERO  = 8'd48;
   localparam logic [7:0]  CHAR_NINE  = 8'd57;
   localparam logic [16:0] NUM_LIMIT  = 17'd99999;
   localparam logic [3:0]  NUM_RADIX  = 4'd10;
   localparam logic [2:0]  COLOUR_LAST = 3'd5;

   localparam int EVQ_DEPTH = 2;
   localparam int RSPQ_DEPTH = 2;

   localparam logic KIND_HEADER = 1'b0;
   localparam logic KIND_RUN    = 1'b1;

   typedef struct packed {
      logic [7:0] char_code;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [16:0] first_value;
      logic [16:0] second_value;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [33:0] start_index;
      logic        overrun;
   } rsp_type;

   typedef struct packed {
      logic        kind;
      logic [16:0] first_value;
      logic [16:0] second_value;
      logic [23:0] colour;
   } event_type;

endpackage

`default_nettype wire

[hw/rtl/rtrd_fifo.sv]
// rtrd_fifo: small synchronous queue with push/full and pop/empty sides
// generic width and depth, no dependencies
`default_nettype none

module rtrd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             pop,
   output logic                  empty,
   output logic [WIDTH-1:0]      rd_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/rtrd_front.sv]
// rtrd_front: character parser, accumulates number fields and colour nibbles
// pushes header and run transactions into the event queue; uses rtrd_pkg
`default_nettype none

module rtrd_front #(
   parameter int MAX_DIGITS = 5
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire rtrd_pkg::req_type req_data,
   output logic                   ev_push,
   output rtrd_pkg::event_type    ev_data
);

   localparam int DCW = $clog2(MAX_DIGITS + 1);

   localparam logic [1:0] PH_WIDTH  = 2'd0;
   localparam logic [1:0] PH_HEIGHT = 2'd1;
   localparam logic [1:0] PH_COUNT  = 2'd2;
   localparam logic [1:0] PH_COLOUR = 2'd3;

   logic [1:0]     phase_ff, phase_in;
   logic [16:0]    acc_ff, acc_in;
   logic [DCW-1:0] cnt_ff, cnt_in;
   logic [2:0]     pos_ff, pos_in;
   logic [23:0]    colour_ff, colour_in;
   logic [16:0]    width_ff, width_in;

   logic [1:0]     ph;
   logic [16:0]    acc;
   logic [DCW-1:0] cnt;
   logic [2:0]     pos;
   logic [23:0]    colour;
   logic [16:0]    width;
   logic [7:0]     c;
   logic [7:0]     offset;
   logic           is_space, is_digit;
   logic [20:0]    acc_next;
   logic [16:0]    acc_num;
   logic [23:0]    colour_shift;

   assign c      = req_data.char_code;
   assign offset = c - rtrd_pkg::CHAR_ZERO;

   always_comb begin
      if (req_data.frame_start) begin
         ph     = PH_WIDTH;
         acc    = '0;
         cnt    = '0;
         pos    = '0;
         colour = '0;
         width  = '0;
      end else begin
         ph     = phase_ff;
         acc    = acc_ff;
         cnt    = cnt_ff;
         pos    = pos_ff;
         colour = colour_ff;
         width  = width_ff;
      end

      is_space = (c == rtrd_pkg::CHAR_SPACE);
      is_digit = c inside {[rtrd_pkg::CHAR_ZERO:rtrd_pkg::CHAR_NINE]};
      acc_next = 21'(acc) * 21'(rtrd_pkg::NUM_RADIX) + 21'(offset[3:0]);
      acc_num  = (acc_next > 21'(rtrd_pkg::NUM_LIMIT)) ? rtrd_pkg::NUM_LIMIT
                                                       : acc_next[16:0];
      colour_shift = {colour[19:0], offset[3:0]};

      phase_in  = ph;
      acc_in    = acc;
      cnt_in    = cnt;
      pos_in    = pos;
      colour_in = colour;
      width_in  = width;
      ev_push   = 1'b0;
      ev_data   = '0;

      case (ph)
         PH_WIDTH, PH_HEIGHT, PH_COUNT: begin
            if (is_space) begin
               acc_in = '0;
               cnt_in = '0;
               case (ph)
                  PH_WIDTH: begin
                     width_in = acc;
                     phase_in = PH_HEIGHT;
                  end
                  PH_HEIGHT: begin
                     phase_in             = PH_COUNT;
                     ev_push              = accept;
                     ev_data.kind         = rtrd_pkg::KIND_HEADER;
                     ev_data.first_value  = width;
                     ev_data.second_value = acc;
                  end
                  default: begin
                     acc_in    = acc;
                     pos_in    = '0;
                     colour_in = '0;
                     phase_in  = PH_COLOUR;
                  end
               endcase
            end else if (is_digit && (cnt < DCW'(MAX_DIGITS))) begin
               acc_in = acc_num;
               cnt_in = cnt + DCW'(1);
            end
         end
         default: begin
            if (pos == rtrd_pkg::COLOUR_LAST) begin
               ev_push             = accept;
               ev_data.kind        = rtrd_pkg::KIND_RUN;
               ev_data.first_value = acc;
               ev_data.colour      = colour_shift;
               acc_in              = '0;
               cnt_in              = '0;
               pos_in              = '0;
               colour_in           = '0;
               phase_in            = PH_COUNT;
            end else begin
               colour_in = colour_shift;
               pos_in    = pos + 3'd1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_WIDTH;
         acc_ff    <= '0;
         cnt_ff    <= '0;
         pos_ff    <= '0;
         colour_ff <= '0;
         width_ff  <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         acc_ff    <= acc_in;
         cnt_ff    <= cnt_in;
         pos_ff    <= pos_in;
         colour_ff <= colour_in;
         width_ff  <= width_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/rtrd_back.sv]
// rtrd_back: executes header and run transactions from the event queue
// tracks pixel total and next start index, builds responses; uses rtrd_pkg
`default_nettype none

module rtrd_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                ev_valid,
   input  wire rtrd_pkg::event_type ev_data,
   input  wire logic                rsp_full,
   output logic                     ev_pop,
   output logic                     rsp_push,
   output rtrd_pkg::rsp_type        rsp_data
);

   logic [33:0] total_ff, total_in;
   logic [33:0] next_ff, next_in;
   logic [34:0] run_end;

   assign ev_pop   = ev_valid && !rsp_full;
   assign rsp_push = ev_pop;
   assign run_end  = {1'b0, next_ff} + 35'(ev_data.first_value);

   always_comb begin
      total_in = total_ff;
      next_in  = next_ff;
      rsp_data = '0;
      rsp_data.kind        = ev_data.kind;
      rsp_data.first_value = ev_data.first_value;
      if (ev_data.kind == rtrd_pkg::KIND_HEADER) begin
         rsp_data.second_value = ev_data.second_value;
         total_in = 34'(ev_data.first_value) * 34'(ev_data.second_value);
         next_in  = '0;
      end else begin
         rsp_data.red         = ev_data.colour[23:16];
         rsp_data.green       = ev_data.colour[15:8];
         rsp_data.blue        = ev_data.colour[7:0];
         rsp_data.start_index = next_ff;
         rsp_data.overrun     = (run_end > {1'b0, total_ff});
         next_in = run_end[34] ? '1 : run_end[33:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         next_ff  <= '0;
      end else if (ev_pop) begin
         total_ff <= total_in;
         next_ff  <= next_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/rle_text_run_decoder.sv]
// rle_text_run_decoder: top level of the text run-length decoder
// parser front, event queue, executing back and response queue; uses rtrd_pkg
//
//   channel   ports                        handshake
//   request   push, full, req_data         accepted on push && !full
//   response  empty, pop, rsp_data         accepted on pop && !empty
//
// one character per cycle while full is low; a result reaches the response queue head
// by way of the event queue and the back once the character completing it is accepted
// full follows the two-entry event queue; the back stalls on a full response queue
// synchronous reset clears parser state, queue pointers, pixel total and index
`default_nettype none

module rle_text_run_decoder #(
   parameter int MAX_DIGITS = 5
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire rtrd_pkg::req_type req_data,
   output logic                   empty,
   input  wire logic              pop,
   output rtrd_pkg::rsp_type      rsp_data
);

   localparam int EVW  = $bits(rtrd_pkg::event_type);
   localparam int RSPW = $bits(rtrd_pkg::rsp_type);

   logic                accept;
   logic                ev_push, ev_pop, ev_full, ev_empty;
   rtrd_pkg::event_type ev_wr, ev_rd;
   logic                rsp_push, rsp_full;
   rtrd_pkg::rsp_type   rsp_wr;

   assign full   = ev_full;
   assign accept = push && !ev_full;

   rtrd_front #(
      .MAX_DIGITS(MAX_DIGITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .req_data(req_data),
      .ev_push (ev_push),
      .ev_data (ev_wr)
   );

   rtrd_fifo #(
      .WIDTH(EVW),
      .DEPTH(rtrd_pkg::EVQ_DEPTH)
   ) u_evq (
      .clock  (clock),
      .reset  (reset),
      .push   (ev_push),
      .full   (ev_full),
      .wr_data(ev_wr),
      .pop    (ev_pop),
      .empty  (ev_empty),
      .rd_data(ev_rd)
   );

   rtrd_back u_back (
      .clock   (clock),
      .reset   (reset),
      .ev_valid(!ev_empty),
      .ev_data (ev_rd),
      .rsp_full(rsp_full),
      .ev_pop  (ev_pop),
      .rsp_push(rsp_push),
      .rsp_data(rsp_wr)
   );

   rtrd_fifo #(
      .WIDTH(RSPW),
      .DEPTH(rtrd_pkg::RSPQ_DEPTH)
   ) u_rspq (
      .clock  (clock),
      .reset  (reset),
      .push   (rsp_push),
      .full   (rsp_full),
      .wr_data(rsp_wr),
      .pop    (pop),
      .empty  (empty),
      .rd_data(rsp_data)
   );

endmodule

`default_nettype wire
